### hdl/itbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itbs_pkg
// Shared types and constants for the interval table binary search block.
// ----------------------------------------------------------------------------
package itbs_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    // search bounds run from 0 up to TABLE_DEPTH inclusive
    localparam int BND_W       = $clog2(TABLE_DEPTH + 1);

    // field widths
    localparam int CODE_W  = 24;
    localparam int ID_W    = 16;
    localparam int INDEX_W = 12;
    localparam int COUNT_W = 13;
    localparam int ENTRY_W = 2 * CODE_W + ID_W;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = COUNT_W;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_READY = 1'd1;

    // item actions
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    // one stored interval
    typedef struct packed {
        logic [CODE_W-1:0] range_start;
        logic [CODE_W-1:0] range_end;
        logic [ID_W-1:0]   item_id;
    } t_entry;

    // search sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

### hdl/interval_table_binary_search_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// interval_table_binary_search_top
// Interval table in block RAM with a binary-search lookup sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall): a write item (action 0) stores one
//   interval at entry_index and gives no result; a lookup item (action 1)
//   searches the first entry_count entries for query_code and gives exactly
//   one result item on the output channel (o_valid / i_stall).
//   Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 sets
//   entry_count (saturated to the table depth), index 1 sets table_ready.
//   A lookup runs a RAM read, then a compare, for each probe: up to 13
//   probes on a 4096-entry table before the result register is loaded.
//   A table not ready or empty answers without a probe. The single RAM
//   read port is used once per probe; lookups are handled one at a time.
//   A finished result sits in an output register, so the next item is
//   accepted while that result still waits; a later lookup only waits at
//   its end if the previous result has not been taken.
//   Reset clears entry_count and table_ready; the table contents are
//   undefined until written. A stalled result holds its value.
// ----------------------------------------------------------------------------
module interval_table_binary_search_top
    import itbs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input items
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic                  i_action,
    input  wire logic [INDEX_W-1:0]    i_entry_index,
    input  wire logic [CODE_W-1:0]     i_range_start,
    input  wire logic [CODE_W-1:0]     i_range_end,
    input  wire logic [ID_W-1:0]       i_item_id,
    input  wire logic [CODE_W-1:0]     i_query_code,
    // result items
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic                       o_found,
    output logic      [ID_W-1:0]       o_result_id,
    // configuration writes
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers
    logic [COUNT_W-1:0] r_entry_count;
    logic               r_table_ready;

    // sequencer state
    t_state             r_state, n_state;
    logic [CODE_W-1:0]  r_query, n_query;
    logic [BND_W-1:0]   r_low, n_low;
    logic [BND_W-1:0]   r_hi, n_hi;     // exclusive upper bound
    logic [BND_W-1:0]   r_mid, n_mid;
    logic               r_found, n_found;
    logic [ID_W-1:0]    r_id, n_id;

    // output register
    logic               r_out_valid, n_out_valid;
    logic               r_out_found, n_out_found;
    logic [ID_W-1:0]    r_out_id, n_out_id;

    // datapath
    logic               in_accept;
    logic               wr_en;
    logic               rd_en;
    logic [BND_W-1:0]   probe_mid;
    logic [BND_W-1:0]   count_sat;
    logic [BND_W-1:0]   step_low;
    logic [BND_W-1:0]   step_hi;
    logic [ENTRY_W-1:0] rd_data;
    t_entry             wr_entry;
    t_entry             rd_entry;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != S_IDLE);
    assign in_accept   = i_valid && !o_stall;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
            r_table_ready <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ENTRY_COUNT: r_entry_count <= i_cfg_data[COUNT_W-1:0];
                CFG_TABLE_READY: r_table_ready <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // entry count saturated to the table depth
    always_comb begin
        if (32'(r_entry_count) > 32'(TABLE_DEPTH)) begin
            count_sat = BND_W'(TABLE_DEPTH);
        end else begin
            count_sat = BND_W'(r_entry_count);
        end
    end

    // table write on an accepted write item inside the table
    assign wr_entry.range_start = i_range_start;
    assign wr_entry.range_end   = i_range_end;
    assign wr_entry.item_id     = i_item_id;
    assign wr_en = in_accept && (i_action == ACT_WRITE)
                   && (32'(i_entry_index) < 32'(TABLE_DEPTH));

    // midpoint of the current window: low + (high - low - 1) / 2, high exclusive
    assign probe_mid = r_low + ((r_hi - r_low - BND_W'(1)) >> 1);
    assign rd_en     = (r_state == S_PROBE);

    itbs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (ADDR_W'(i_entry_index)),
        .i_wr_data (wr_entry),
        .i_rd_en   (rd_en),
        .i_rd_addr (probe_mid[ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    assign rd_entry = t_entry'(rd_data);

    // window update from the probed entry
    always_comb begin
        step_low = r_low;
        step_hi  = r_hi;
        if (rd_entry.range_start > r_query) begin
            step_hi = r_mid;
        end else if (rd_entry.range_end < r_query) begin
            step_low = r_mid + BND_W'(1);
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // search and output payload
    always_ff @(posedge i_clk) begin
        r_query     <= n_query;
        r_low       <= n_low;
        r_hi        <= n_hi;
        r_mid       <= n_mid;
        r_found     <= n_found;
        r_id        <= n_id;
        r_out_found <= n_out_found;
        r_out_id    <= n_out_id;
    end

    // next state and outputs
    always_comb begin
        n_state     = r_state;
        n_query     = r_query;
        n_low       = r_low;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_found     = r_found;
        n_id        = r_id;
        n_out_valid = r_out_valid;
        n_out_found = r_out_found;
        n_out_id    = r_out_id;

        // result taken by the receiver
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept && (i_action == ACT_LOOKUP)) begin
                    n_query = i_query_code;
                    n_found = 1'b0;
                    n_id    = '0;
                    n_low   = '0;
                    n_hi    = count_sat;
                    if (!r_table_ready || (count_sat == '0)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                n_mid   = probe_mid;
                n_state = S_CMP;
            end
            S_CMP: begin
                if ((rd_entry.range_start > r_query) || (rd_entry.range_end < r_query)) begin
                    n_low = step_low;
                    n_hi  = step_hi;
                    if (step_low < step_hi) begin
                        n_state = S_PROBE;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_found = 1'b1;
                    n_id    = rd_entry.item_id;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_found;
                    n_out_id    = r_id;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid     = r_out_valid;
    assign o_found     = r_out_found;
    assign o_result_id = r_out_id;

`ifndef SYNTHESIS
    // a probe is only issued on a non-empty window
    a_window_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_low < r_hi))
        else $error("probe issued on an empty search window");

    // the window never reaches past the table
    a_window_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (32'(r_hi) <= 32'(TABLE_DEPTH)))
        else $error("search bound beyond table depth");

    // a not found result carries id zero
    a_miss_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_id == '0))
        else $error("not found result with nonzero id");

    // a new result comes only out of the finish state
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> ($past(r_state) == S_DONE))
        else $error("result loaded outside the finish state");

    // no table write while a lookup is in flight
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == S_IDLE))
        else $error("table write during a lookup");
`endif

endmodule
`default_nettype wire

### hdl/itbs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itbs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module itbs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

### sim/tb_interval_table_binary_search_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_interval_table_binary_search_top
// Self-checking bench for the interval table search block. A table of sorted
// intervals is loaded, lookups are issued under several idle and stall
// patterns and one long output hold-off, and every result item is compared
// with a binary search over a local copy of the table.
// ----------------------------------------------------------------------------
module tb_interval_table_binary_search_top;
    import itbs_pkg::*;

    localparam int RUN_LIMIT     = 600000;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASE_ITEMS   = 70;
    localparam int SMALL_TABLE   = 40;
    localparam int TREE_NODES    = 31;
    localparam int TOP_NODES     = 63;
    localparam int SLOT_PITCH    = 4096;
    localparam int PICK_TRIES    = 16;

    // one expected lookup answer
    typedef struct packed {
        logic            found;
        logic [ID_W-1:0] id;
    } t_answer;

    // table mirror, search predictor and pending answers
    class interval_lookup_board;
        t_entry             slots [TABLE_DEPTH];
        logic [COUNT_W-1:0] entry_count;
        logic               table_ready;
        t_answer            pending_answers [$];
        int                 mismatch_count;

        function new();
            entry_count    = '0;
            table_ready    = 1'b0;
            mismatch_count = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_ENTRY_COUNT) begin
                entry_count = data[COUNT_W-1:0];
            end else if (idx == CFG_TABLE_READY) begin
                table_ready = data[0];
            end
        endfunction

        // binary search with the low + (high - low) / 2 probe order
        function t_answer search_table(logic [CODE_W-1:0] code);
            t_answer ans;
            int      span;
            int      low;
            int      high;
            int      mid;
            ans.found = 1'b0;
            ans.id    = '0;
            span = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
            if (!table_ready || span == 0) begin
                return ans;
            end
            low  = 0;
            high = span - 1;
            while (low <= high) begin
                mid = low + (high - low) / 2;
                if (slots[mid].range_start > code) begin
                    high = mid - 1;
                end else if (slots[mid].range_end < code) begin
                    low = mid + 1;
                end else begin
                    ans.found = 1'b1;
                    ans.id    = slots[mid].item_id;
                    return ans;
                end
            end
            return ans;
        endfunction

        function void note_item(logic act, logic [INDEX_W-1:0] idx,
                                logic [CODE_W-1:0] lo_code, logic [CODE_W-1:0] hi_code,
                                logic [ID_W-1:0] id, logic [CODE_W-1:0] code);
            if (act == ACT_WRITE) begin
                if (idx < TABLE_DEPTH) begin
                    slots[idx] = '{range_start: lo_code, range_end: hi_code, item_id: id};
                end
            end else begin
                pending_answers.push_back(search_table(code));
            end
        endfunction

        function void flag(string what);
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
                $display("%0t: %s", $time, what);
            end
        endfunction

        function void check_result(logic found, logic [ID_W-1:0] id);
            t_answer want;
            if (pending_answers.size() == 0) begin
                flag($sformatf("result with no lookup waiting: found=%0b id=%h", found, id));
                return;
            end
            want = pending_answers.pop_front();
            if (found !== want.found || id !== want.id) begin
                flag($sformatf("lookup result: expected found=%0b id=%h, got found=%0b id=%h",
                               want.found, want.id, found, id));
            end
        endfunction
    endclass

    // block ports
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_valid       = 1'b0;
    logic                  o_stall;
    logic                  i_action      = ACT_WRITE;
    logic [INDEX_W-1:0]    i_entry_index = '0;
    logic [CODE_W-1:0]     i_range_start = '0;
    logic [CODE_W-1:0]     i_range_end   = '0;
    logic [ID_W-1:0]       i_item_id     = '0;
    logic [CODE_W-1:0]     i_query_code  = '0;
    logic                  o_valid;
    logic                  i_stall       = 1'b0;
    logic                  o_found;
    logic [ID_W-1:0]       o_result_id;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = CFG_ENTRY_COUNT;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    // bench state
    interval_lookup_board lookup_board = new();
    logic [CODE_W-1:0]    plan_start   [TABLE_DEPTH];
    logic [CODE_W-1:0]    plan_end     [TABLE_DEPTH];
    bit                   plan_written [TABLE_DEPTH];
    int                   live_slots [$];
    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;
    int                   hold_len       = 0;
    int                   cycle_count    = 0;

    interval_table_binary_search_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_entry_index (i_entry_index),
        .i_range_start (i_range_start),
        .i_range_end   (i_range_end),
        .i_item_id     (i_item_id),
        .i_query_code  (i_query_code),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_found       (o_found),
        .o_result_id   (o_result_id),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    always #6 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // handshake monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                lookup_board.set_reg(i_cfg_index, i_cfg_data);
            end
            if (i_valid && !o_stall) begin
                lookup_board.note_item(i_action, i_entry_index, i_range_start, i_range_end,
                                       i_item_id, i_query_code);
            end
            if (o_valid && !i_stall) begin
                lookup_board.check_result(o_found, o_result_id);
            end
        end
    end

    // result receiver: random stalls or a counted hold-off
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_len > 0) begin
                i_stall  <= 1'b1;
                hold_len = hold_len - 1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // offer one item and wait until it is taken
    task automatic send_item(input logic act, input logic [INDEX_W-1:0] idx,
                             input logic [CODE_W-1:0] lo_code, input logic [CODE_W-1:0] hi_code,
                             input logic [ID_W-1:0] id, input logic [CODE_W-1:0] code);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_action      <= act;
        i_entry_index <= idx;
        i_range_start <= lo_code;
        i_range_end   <= hi_code;
        i_item_id     <= id;
        i_query_code  <= code;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic store_entry(input logic [INDEX_W-1:0] idx, input logic [CODE_W-1:0] lo_code,
                               input logic [CODE_W-1:0] hi_code, input logic [ID_W-1:0] id);
        plan_start[idx]   = lo_code;
        plan_end[idx]     = hi_code;
        plan_written[idx] = 1'b1;
        live_slots.push_back(int'(idx));
        send_item(ACT_WRITE, idx, lo_code, hi_code, id, CODE_W'($urandom));
    endtask

    // the entry fields of a lookup are ignored, so they carry noise
    task automatic lookup_code(input logic [CODE_W-1:0] code);
        send_item(ACT_LOOKUP, INDEX_W'($urandom), CODE_W'($urandom), CODE_W'($urandom),
                  ID_W'($urandom), code);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop offering, wait for every answer, then let a search run out
    task automatic settle();
        i_valid <= 1'b0;
        while (lookup_board.pending_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // sorted intervals in slots 0..n-1, some single codes, some inverted
    task automatic load_sorted(input int n);
        int unsigned pitch;
        int unsigned lo_code;
        int unsigned hi_code;
        int          k;
        pitch = 32'hFF_FFFF / (n + 1);
        for (k = 0; k < n; k++) begin
            lo_code = k * pitch + $urandom_range(0, pitch / 2);
            case ($urandom_range(7))
                0: hi_code = (lo_code > 1000) ? lo_code - $urandom_range(1, 1000) : lo_code;
                1: hi_code = lo_code;
                default: hi_code = lo_code + $urandom_range(0, pitch / 2 - 1);
            endcase
            store_entry(INDEX_W'(k), CODE_W'(lo_code), CODE_W'(hi_code),
                        ($urandom_range(7) == 0) ? '0 : ID_W'($urandom));
        end
    endtask

    // top of the search tree for a span, breadth first, codes rising with the slot
    task automatic load_tree(input int span, input int nodes);
        int lows [$];
        int highs [$];
        int lo;
        int hi;
        int mid;
        int base;
        int done;
        done = 0;
        lows.push_back(0);
        highs.push_back(span);
        while (lows.size() != 0 && done < nodes) begin
            lo = lows.pop_front();
            hi = highs.pop_front();
            if (lo < hi) begin
                mid  = lo + (hi - lo - 1) / 2;
                base = mid * SLOT_PITCH + $urandom_range(0, 1023);
                store_entry(INDEX_W'(mid), CODE_W'(base), CODE_W'(base + $urandom_range(0, 2047)),
                            ID_W'($urandom));
                done++;
                lows.push_back(lo);
                highs.push_back(mid);
                lows.push_back(mid + 1);
                highs.push_back(hi);
            end
        end
    endtask

    // mostly codes inside a live entry, then edges, noise and extremes
    function automatic logic [CODE_W-1:0] pick_query(input int count);
        int span;
        int k;
        int sel;
        int tries;
        span = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
        if (span == 0 || live_slots.size() == 0) begin
            return CODE_W'($urandom);
        end
        k = $urandom_range(0, span - 1);
        for (tries = 0; tries < PICK_TRIES && (k >= span || !plan_written[k]); tries++) begin
            k = live_slots[$urandom_range(0, live_slots.size() - 1)];
        end
        if (k >= span || !plan_written[k]) begin
            return CODE_W'($urandom);
        end
        sel = $urandom_range(99);
        if (sel < 60 && plan_start[k] <= plan_end[k]) begin
            return CODE_W'(plan_start[k] + $urandom_range(0, plan_end[k] - plan_start[k]));
        end else if (sel < 70) begin
            return plan_start[k] - 1'b1;
        end else if (sel < 80) begin
            return plan_end[k] + 1'b1;
        end else if (sel < 90) begin
            return CODE_W'($urandom);
        end
        return $urandom_range(1) ? '0 : '1;
    endfunction

    // true when every slot that a lookup of this code probes has been written
    function automatic bit probes_written(input logic [CODE_W-1:0] code);
        int span;
        int low;
        int high;
        int mid;
        span = (lookup_board.entry_count > TABLE_DEPTH) ? TABLE_DEPTH
                                                        : int'(lookup_board.entry_count);
        if (!lookup_board.table_ready || span == 0) begin
            return 1'b1;
        end
        low  = 0;
        high = span - 1;
        while (low <= high) begin
            mid = low + (high - low) / 2;
            if (!plan_written[mid]) begin
                return 1'b0;
            end
            if (plan_start[mid] > code) begin
                high = mid - 1;
            end else if (plan_end[mid] < code) begin
                low = mid + 1;
            end else begin
                return 1'b1;
            end
        end
        return 1'b1;
    endfunction

    // lookup of a code whose search stays on written slots, skipped if none is found
    task automatic lookup_live(input int count);
        logic [CODE_W-1:0] code;
        int                tries;
        for (tries = 0; tries < PICK_TRIES; tries++) begin
            code = pick_query(count);
            if (probes_written(code)) begin
                lookup_code(code);
                return;
            end
        end
    endtask

    // stimulus
    initial begin
        int phase;
        int k;
        int count;
        logic ready_bit;
        int send_pcts [4] = '{0, 63, 0, 20};
        int recv_pcts [4] = '{0, 0, 63, 20};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // out of reset: not ready, empty
        lookup_code('0);
        lookup_code('1);
        settle();
        write_reg(CFG_ENTRY_COUNT, '0);
        write_reg(CFG_TABLE_READY, 1);
        lookup_code(CODE_W'($urandom));
        settle();
        // count set but table not ready
        write_reg(CFG_ENTRY_COUNT, 5);
        write_reg(CFG_TABLE_READY, 0);
        lookup_code(CODE_W'($urandom));

        // small table: zero interval with id zero, inverted entry, top of the code range
        store_entry(0, 24'h00_0000, 24'h00_0000, 16'h0000);
        store_entry(1, 24'h00_0064, 24'h00_0032, 16'h1234);
        store_entry(2, 24'h00_03E8, 24'h00_07D0, 16'hABCD);
        store_entry(3, 24'hFF_FFF0, 24'hFF_FFFF, 16'hFFFF);
        settle();
        write_reg(CFG_ENTRY_COUNT, 4);
        write_reg(CFG_TABLE_READY, 1);
        lookup_code(24'h00_0000);
        lookup_code(24'h00_004B);
        lookup_code(24'h00_05DC);
        lookup_code(24'h00_07D1);
        lookup_code(24'hFF_FFFF);

        // count above the table depth, over the top of the full-depth tree
        settle();
        load_tree(TABLE_DEPTH, TOP_NODES);
        settle();
        write_reg(CFG_ENTRY_COUNT, '1);
        repeat (6) lookup_live(TABLE_DEPTH);

        // random phases over the idle patterns
        for (phase = 0; phase < 8; phase++) begin
            settle();
            send_idle_pct  = send_pcts[phase % 4];
            recv_stall_pct = recv_pcts[phase % 4];
            case ($urandom_range(9))
                0: count = 0;
                1: count = TABLE_DEPTH;
                2: count = $urandom_range(TABLE_DEPTH + 1, 8191);
                3: count = $urandom_range(SMALL_TABLE + 1, TABLE_DEPTH - 1);
                default: count = $urandom_range(1, SMALL_TABLE);
            endcase
            ready_bit = ($urandom_range(7) != 0);
            write_reg(CFG_ENTRY_COUNT, CFG_DATA_W'(count));
            write_reg(CFG_TABLE_READY, {($urandom_range(1) ? 12'($urandom) : 12'h000), ready_bit});
            if (count > 0 && count <= SMALL_TABLE) begin
                load_sorted(count);
            end else if (count > SMALL_TABLE) begin
                load_tree((count > TABLE_DEPTH) ? TABLE_DEPTH : count, TREE_NODES);
            end
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(99) < 85) begin
                    lookup_live(count);
                end else begin
                    store_entry(INDEX_W'($urandom), CODE_W'($urandom), CODE_W'($urandom),
                                ID_W'($urandom));
                end
            end
        end

        // output held off while lookups keep coming, so the input backs up
        settle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_reg(CFG_ENTRY_COUNT, CFG_DATA_W'(TABLE_DEPTH));
        write_reg(CFG_TABLE_READY, 1);
        load_tree(TABLE_DEPTH, TREE_NODES);
        hold_len = 400;
        for (k = 0; k < 30; k++) begin
            lookup_live(TABLE_DEPTH);
        end

        settle();
        if (lookup_board.mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/itbs_pkg.sv
hdl/itbs_ram.sv
hdl/interval_table_binary_search_top.sv
sim/tb_interval_table_binary_search_top.sv
